@@ design/hsvc_pkg.sv @@
// hsvc_pkg: shared types and constants for the hsv to rgb converter pipeline
// no dependencies; imported by every module of the design
package hsvc_pkg;

   localparam int PCT_W    = 7;
   localparam int HUE_W    = 9;
   localparam int FRAC_W   = 10;
   localparam int REM_W    = 6;
   localparam int K_W      = 16;
   localparam int SX_W     = PCT_W + FRAC_W;
   localparam int PROD_W   = 23;
   localparam int SCALED_W = 31;
   localparam int NUM_W    = 24;
   localparam int RECIP_W  = 25;
   localparam int FULL_W   = NUM_W + RECIP_W;
   localparam int COL_W    = 8;
   localparam int PRE_SHIFT   = 7;
   localparam int RECIP_SHIFT = 40;
   localparam int SECTOR_SPAN = 60;
   localparam int NUM_CH      = 4;
   localparam int NUM_K       = 3;

   localparam logic [PCT_W-1:0]   PERCENT_MAX = 7'd100;
   localparam logic [HUE_W-1:0]   HUE_LIMIT   = 9'd360;
   localparam logic [FRAC_W-1:0]  FRAC_ONE    = 10'd600;
   localparam logic [FRAC_W-1:0]  CLAMP_FRAC  = 10'd594;
   localparam logic [K_W-1:0]     UNIT_K      = 16'd60000;
   // ceil(2^40 / 46875); 6000000 = 128 * 46875
   localparam logic [RECIP_W-1:0] RECIP       = 25'd23456249;

   // factor indices: 1-s, 1-s*f, 1-s*(1-f)
   localparam logic [1:0] KI_ONE = 2'd0;
   localparam logic [1:0] KI_F   = 2'd1;
   localparam logic [1:0] KI_INV = 2'd2;

   // channel indices: v, v(1-s), v(1-s*f), v(1-s*(1-f))
   localparam logic [1:0] CH_V   = 2'd0;
   localparam logic [1:0] CH_ONE = 2'd1;
   localparam logic [1:0] CH_F   = 2'd2;
   localparam logic [1:0] CH_INV = 2'd3;

   typedef enum logic [2:0] {
      SEC_RED_YELLOW    = 3'd0,
      SEC_YELLOW_GREEN  = 3'd1,
      SEC_GREEN_CYAN    = 3'd2,
      SEC_CYAN_BLUE     = 3'd3,
      SEC_BLUE_MAGENTA  = 3'd4,
      SEC_MAGENTA_RED   = 3'd5
   } sector_type;

   typedef struct packed {
      sector_type        sector;
      logic [FRAC_W-1:0] frac;
      logic [PCT_W-1:0]  sat;
      logic [PCT_W-1:0]  val;
   } decode_type;

   typedef struct packed {
      sector_type                  sector;
      logic [PCT_W-1:0]            val;
      logic [NUM_K-1:0][K_W-1:0]   k;
   } factor_type;

   typedef struct packed {
      sector_type                     sector;
      logic [NUM_CH-1:0][PROD_W-1:0]  prod;
   } prod_type;

endpackage

@@ design/hsvc_sector.sv @@
// hsvc_sector: first stage, clamps saturation and value, splits hue into sector and fraction
// depends on hsvc_pkg
module hsvc_sector
   import hsvc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [HUE_W-1:0] hue,
   input  logic [PCT_W-1:0] saturation,
   input  logic [PCT_W-1:0] brightness,
   output logic             out_valid,
   output decode_type       out_data
);

   logic             valid_ff;
   decode_type       data_ff;
   decode_type       data_in;
   logic [HUE_W-1:0] base;
   logic [REM_W-1:0] rem;

   always_comb begin
      data_in.sat = (saturation > PERCENT_MAX) ? PERCENT_MAX : saturation;
      data_in.val = (brightness > PERCENT_MAX) ? PERCENT_MAX : brightness;
      base = '0;
      data_in.sector = SEC_RED_YELLOW;
      priority if (hue < HUE_W'(SECTOR_SPAN)) begin
         data_in.sector = SEC_RED_YELLOW;
         base = '0;
      end else if (hue < HUE_W'(SECTOR_SPAN * 2)) begin
         data_in.sector = SEC_YELLOW_GREEN;
         base = HUE_W'(SECTOR_SPAN);
      end else if (hue < HUE_W'(SECTOR_SPAN * 3)) begin
         data_in.sector = SEC_GREEN_CYAN;
         base = HUE_W'(SECTOR_SPAN * 2);
      end else if (hue < HUE_W'(SECTOR_SPAN * 4)) begin
         data_in.sector = SEC_CYAN_BLUE;
         base = HUE_W'(SECTOR_SPAN * 3);
      end else if (hue < HUE_W'(SECTOR_SPAN * 5)) begin
         data_in.sector = SEC_BLUE_MAGENTA;
         base = HUE_W'(SECTOR_SPAN * 4);
      end else begin
         data_in.sector = SEC_MAGENTA_RED;
         base = HUE_W'(SECTOR_SPAN * 5);
      end
      rem = REM_W'(hue - base);
      // fraction in 1/600 units: rem * 10
      if (hue >= HUE_LIMIT) begin
         data_in.frac = CLAMP_FRAC;
      end else begin
         data_in.frac = FRAC_W'({rem, 3'b000}) + FRAC_W'({rem, 1'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

@@ design/hsvc_factor.sv @@
// hsvc_factor: second and third stages, channel factors k = 60000 - s*x, then v*k
// depends on hsvc_pkg
module hsvc_factor
   import hsvc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  decode_type in_data,
   output logic       out_valid,
   output prod_type   out_data
);

   logic       fvalid_ff;
   factor_type factor_ff;
   factor_type factor_in;
   logic       pvalid_ff;
   prod_type   prod_ff;
   prod_type   prod_in;
   logic [SX_W-1:0] sx_one;
   logic [SX_W-1:0] sx_f;
   logic [SX_W-1:0] sx_inv;

   // stage two: saturation times each fraction
   always_comb begin
      sx_one = SX_W'(in_data.sat) * SX_W'(FRAC_ONE);
      sx_f   = SX_W'(in_data.sat) * SX_W'(in_data.frac);
      sx_inv = SX_W'(in_data.sat) * SX_W'(FRAC_ONE - in_data.frac);
      factor_in.sector    = in_data.sector;
      factor_in.val       = in_data.val;
      factor_in.k[KI_ONE] = UNIT_K - sx_one[K_W-1:0];
      factor_in.k[KI_F]   = UNIT_K - sx_f[K_W-1:0];
      factor_in.k[KI_INV] = UNIT_K - sx_inv[K_W-1:0];
   end

   // stage three: value times factor
   always_comb begin
      prod_in.sector       = factor_ff.sector;
      prod_in.prod[CH_V]   = PROD_W'(factor_ff.val) * PROD_W'(UNIT_K);
      prod_in.prod[CH_ONE] = PROD_W'(factor_ff.val) * PROD_W'(factor_ff.k[KI_ONE]);
      prod_in.prod[CH_F]   = PROD_W'(factor_ff.val) * PROD_W'(factor_ff.k[KI_F]);
      prod_in.prod[CH_INV] = PROD_W'(factor_ff.val) * PROD_W'(factor_ff.k[KI_INV]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fvalid_ff <= 1'b0;
         pvalid_ff <= 1'b0;
      end else begin
         fvalid_ff <= in_valid;
         pvalid_ff <= fvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      factor_ff <= factor_in;
      prod_ff   <= prod_in;
   end

   assign out_valid = pvalid_ff;
   assign out_data  = prod_ff;

endmodule

@@ design/hsvc_scale.sv @@
// hsvc_scale: fourth and fifth stages, scale by 255/6000000 with exact floor, then sector select
// depends on hsvc_pkg
module hsvc_scale
   import hsvc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  prod_type         in_data,
   output logic             out_valid,
   output logic [COL_W-1:0] red,
   output logic [COL_W-1:0] green,
   output logic [COL_W-1:0] blue
);

   logic                          nvalid_ff;
   sector_type                    sector_ff;
   logic [NUM_CH-1:0][NUM_W-1:0]  num_ff;
   logic [NUM_CH-1:0][NUM_W-1:0]  num_in;
   logic [NUM_CH-1:0][SCALED_W-1:0] scaled;
   logic [NUM_CH-1:0][FULL_W-1:0] full;
   logic [NUM_CH-1:0][COL_W-1:0]  chan;
   logic                          valid_ff;
   logic [COL_W-1:0]              red_ff;
   logic [COL_W-1:0]              green_ff;
   logic [COL_W-1:0]              blue_ff;
   logic [COL_W-1:0]              red_in;
   logic [COL_W-1:0]              green_in;
   logic [COL_W-1:0]              blue_in;

   // stage four: p * 255, dropping the power-of-two part of the divisor
   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         scaled[i] = SCALED_W'({in_data.prod[i], 8'h00}) - SCALED_W'(in_data.prod[i]);
         num_in[i] = scaled[i][SCALED_W-1:PRE_SHIFT];
      end
   end

   // stage five: reciprocal multiply by 1/46875 is exact over the range, then select
   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         full[i] = FULL_W'(num_ff[i]) * FULL_W'(RECIP);
         chan[i] = full[i][RECIP_SHIFT +: COL_W];
      end
      red_in   = chan[CH_V];
      green_in = chan[CH_INV];
      blue_in  = chan[CH_ONE];
      unique case (sector_ff)
         SEC_RED_YELLOW: begin
            red_in = chan[CH_V];   green_in = chan[CH_INV]; blue_in = chan[CH_ONE];
         end
         SEC_YELLOW_GREEN: begin
            red_in = chan[CH_F];   green_in = chan[CH_V];   blue_in = chan[CH_ONE];
         end
         SEC_GREEN_CYAN: begin
            red_in = chan[CH_ONE]; green_in = chan[CH_V];   blue_in = chan[CH_INV];
         end
         SEC_CYAN_BLUE: begin
            red_in = chan[CH_ONE]; green_in = chan[CH_F];   blue_in = chan[CH_V];
         end
         SEC_BLUE_MAGENTA: begin
            red_in = chan[CH_INV]; green_in = chan[CH_ONE]; blue_in = chan[CH_V];
         end
         default: begin
            red_in = chan[CH_V];   green_in = chan[CH_ONE]; blue_in = chan[CH_F];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nvalid_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         nvalid_ff <= in_valid;
         valid_ff  <= nvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      sector_ff <= in_data.sector;
      num_ff    <= num_in;
      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
   end

   assign out_valid = valid_ff;
   assign red       = red_ff;
   assign green     = green_ff;
   assign blue      = blue_ff;

endmodule

@@ design/hsv_to_rgb_converter.sv @@
// hsv_to_rgb_converter: top level, five-stage hsv to rgb colour pipeline
// depends on hsvc_pkg, hsvc_sector, hsvc_factor, hsvc_scale
//
//   channel   ports                                   handshake
//   request   req_hue, req_saturation, req_brightness start high, busy low
//   response  rsp_red, rsp_green, rsp_blue            rsp_valid for one cycle
//
// one transaction per clock; each result passes in order through the decode,
// factor multiply, value multiply, scale and reciprocal multiply stages
// busy is high only during reset; reset clears all pipeline valid bits
// the pipeline never stalls and the receiver takes every result
module hsv_to_rgb_converter
   import hsvc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [HUE_W-1:0] req_hue,
   input  logic [PCT_W-1:0] req_saturation,
   input  logic [PCT_W-1:0] req_brightness,
   output logic             rsp_valid,
   output logic [COL_W-1:0] rsp_red,
   output logic [COL_W-1:0] rsp_green,
   output logic [COL_W-1:0] rsp_blue
);

   logic       accept;
   logic       dec_valid;
   decode_type dec_data;
   logic       prod_valid;
   prod_type   prod_data;

   assign busy   = reset;
   assign accept = start & ~busy;

   hsvc_sector u_sector (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .out_valid  (dec_valid),
      .out_data   (dec_data)
   );

   hsvc_factor u_factor (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_data   (dec_data),
      .out_valid (prod_valid),
      .out_data  (prod_data)
   );

   hsvc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_data   (prod_data),
      .out_valid (rsp_valid),
      .red       (rsp_red),
      .green     (rsp_green),
      .blue      (rsp_blue)
   );

endmodule

@@ design/hsvc_checker.sv @@
// hsvc_checker: port-level checks on the converter, bound to the top level
// depends on hsvc_pkg and hsv_to_rgb_converter
module hsvc_checker
   import hsvc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic [PCT_W-1:0] req_saturation,
   input logic [PCT_W-1:0] req_brightness,
   input logic             rsp_valid,
   input logic [COL_W-1:0] rsp_red,
   input logic [COL_W-1:0] rsp_green,
   input logic [COL_W-1:0] rsp_blue
);

   // every transaction yields a result
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("hsvc: transaction produced no result");

   // no result without an earlier transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 5))
      else $error("hsvc: result without transaction");

   // zero saturation gives grey
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_saturation == '0) |->
         ##5 (rsp_red == rsp_green && rsp_green == rsp_blue))
      else $error("hsvc: zero saturation not grey");

   // zero brightness gives black
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_brightness == '0) |->
         ##5 (rsp_red == '0 && rsp_green == '0 && rsp_blue == '0))
      else $error("hsvc: zero brightness not black");

endmodule

bind hsv_to_rgb_converter hsvc_checker u_hsvc_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_saturation (req_saturation),
   .req_brightness (req_brightness),
   .rsp_valid      (rsp_valid),
   .rsp_red        (rsp_red),
   .rsp_green      (rsp_green),
   .rsp_blue       (rsp_blue)
);
